// ===== hw/rtl/divu_pkg.sv =====
// Shared types and constants for the 32-bit divide/remainder unit.
// No dependencies; every other file of the unit imports this package.
`timescale 1ns / 1ps
`default_nettype none

package divu_pkg;

  // Internal datapath width of the divider (quotient bits per item)
  localparam int DIVU_DATA_WIDTH = 32;

  // Fixed widths of the stream fields
  localparam int OP_W     = 2;
  localparam int FIELD_W  = 32;
  localparam int RESULT_W = 32;

  // Input tdata: op, dividend, divisor packed from bit 0, padded to bytes
  localparam int IN_PACKED_W = OP_W + 2 * FIELD_W;
  localparam int IN_TDATA_W  = ((IN_PACKED_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

  // Entries in the queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_UQUO = 2'd0,
    OP_UREM = 2'd1,
    OP_SQUO = 2'd2,
    OP_SREM = 2'd3
  } divu_op_t;

  // Classification of one item, carried alongside the operand magnitudes
  typedef struct packed {
    divu_op_t op;
    logic     neg_num;
    logic     neg_den;
    logic     den_zero;
  } divu_ctl_t;

  localparam int CTL_W = $bits(divu_ctl_t);

endpackage

`default_nettype wire

// ===== hw/rtl/divu_front.sv =====
// Front end of the divide/remainder unit: accepts an operation, fits the
// operands to the datapath width and classifies signs and zero divisor.
// Depends on divu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module divu_front
  import divu_pkg::*;
#(
  parameter int DATA_WIDTH = DIVU_DATA_WIDTH
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [OP_W-1:0]       in_op,
  input  wire  [FIELD_W-1:0]    in_dividend,
  input  wire  [FIELD_W-1:0]    in_divisor,
  output logic                  out_valid,
  input  wire                   out_ready,
  output divu_ctl_t             out_ctl,
  output logic [DATA_WIDTH-1:0] out_num,
  output logic [DATA_WIDTH-1:0] out_den
);

  logic [DATA_WIDTH-1:0] num_fit;
  logic [DATA_WIDTH-1:0] den_fit;
  logic                  is_signed;
  logic                  neg_num;
  logic                  neg_den;
  divu_ctl_t             ctl_next;

  // Operands are fitted to DATA_WIDTH bits: zero-extended or read in their low bits
  generate
    if (DATA_WIDTH == FIELD_W) begin : g_fit_eq
      assign num_fit = in_dividend;
      assign den_fit = in_divisor;
    end else if (DATA_WIDTH > FIELD_W) begin : g_fit_ext
      assign num_fit = {{(DATA_WIDTH - FIELD_W){1'b0}}, in_dividend};
      assign den_fit = {{(DATA_WIDTH - FIELD_W){1'b0}}, in_divisor};
    end else begin : g_fit_trunc
      assign num_fit = in_dividend[DATA_WIDTH-1:0];
      assign den_fit = in_divisor[DATA_WIDTH-1:0];
    end
  endgenerate

  always_comb begin
    is_signed         = (divu_op_t'(in_op) == OP_SQUO) || (divu_op_t'(in_op) == OP_SREM);
    neg_num           = is_signed && num_fit[DATA_WIDTH-1];
    neg_den           = is_signed && den_fit[DATA_WIDTH-1];
    ctl_next.op       = divu_op_t'(in_op);
    ctl_next.neg_num  = neg_num;
    ctl_next.neg_den  = neg_den;
    ctl_next.den_zero = (den_fit == '0);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_ctl <= ctl_next;
      out_num <= neg_num ? (DATA_WIDTH'(0) - num_fit) : num_fit;
      out_den <= neg_den ? (DATA_WIDTH'(0) - den_fit) : den_fit;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/divu_queue.sv =====
// Small register queue between the front end and the divider pipeline.
// Depends on divu_pkg for the default depth.
`timescale 1ns / 1ps
`default_nettype none

module divu_queue
  import divu_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire  [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = entry[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      entry[wr_ptr] <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/divu_back.sv =====
// Back end of the divide/remainder unit: a DATA_WIDTH-stage restoring
// division pipeline, sign fixup and an output register. Depends on divu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module divu_back
  import divu_pkg::*;
#(
  parameter int DATA_WIDTH = DIVU_DATA_WIDTH
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  divu_ctl_t             in_ctl,
  input  wire  [DATA_WIDTH-1:0] in_num,
  input  wire  [DATA_WIDTH-1:0] in_den,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [RESULT_W-1:0]   out_result
);

  localparam int NSTAGE = DATA_WIDTH + 1;

  // Stage k holds partial remainder, remaining dividend bits in the upper
  // part of qn and quotient bits shifted in from the bottom.
  logic [DATA_WIDTH-1:0] rem_q [NSTAGE];
  logic [DATA_WIDTH-1:0] qn_q  [NSTAGE];
  logic [DATA_WIDTH-1:0] den_q [NSTAGE];
  divu_ctl_t             ctl_q [NSTAGE];
  logic [NSTAGE-1:0]     vld_q;

  logic                  advance;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] rmd;
  logic [DATA_WIDTH-1:0] res_w;
  logic [RESULT_W-1:0]   res_fit;

  // Whole pipeline moves together; it halts only when the result waits
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else if (advance) begin
      vld_q[0] <= in_valid;
    end
    if (advance) begin
      rem_q[0] <= '0;
      qn_q[0]  <= in_num;
      den_q[0] <= in_den;
      ctl_q[0] <= in_ctl;
    end
  end

  generate
    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
      logic [DATA_WIDTH:0]   trial;
      logic [DATA_WIDTH+1:0] diff;
      logic                  take;

      // Shift in the next dividend bit, subtract when it fits
      always_comb begin
        trial = {rem_q[k], qn_q[k][DATA_WIDTH-1]};
        diff  = {1'b0, trial} - {2'b00, den_q[k]};
        take  = !diff[DATA_WIDTH+1];
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld_q[k+1] <= 1'b0;
        end else if (advance) begin
          vld_q[k+1] <= vld_q[k];
        end
        if (advance) begin
          rem_q[k+1] <= take ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
          qn_q[k+1]  <= {qn_q[k][DATA_WIDTH-2:0], take};
          den_q[k+1] <= den_q[k];
          ctl_q[k+1] <= ctl_q[k];
        end
      end
    end
  endgenerate

  assign quo = qn_q[DATA_WIDTH];
  assign rmd = rem_q[DATA_WIDTH];

  always_comb begin
    case (ctl_q[DATA_WIDTH].op)
      OP_UQUO: res_w = quo;
      OP_UREM: res_w = rmd;
      OP_SQUO: res_w = (ctl_q[DATA_WIDTH].neg_num != ctl_q[DATA_WIDTH].neg_den) ?
                       (DATA_WIDTH'(0) - quo) : quo;
      OP_SREM: res_w = ctl_q[DATA_WIDTH].neg_num ? (DATA_WIDTH'(0) - rmd) : rmd;
      default: res_w = '0;
    endcase
    if (ctl_q[DATA_WIDTH].den_zero) begin
      res_w = '0;
    end
  end

  generate
    if (DATA_WIDTH == RESULT_W) begin : g_res_eq
      assign res_fit = res_w;
    end else if (DATA_WIDTH > RESULT_W) begin : g_res_trunc
      assign res_fit = res_w[RESULT_W-1:0];
    end else begin : g_res_ext
      assign res_fit = {{(RESULT_W - DATA_WIDTH){1'b0}}, res_w};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= vld_q[DATA_WIDTH];
    end
    if (advance) begin
      out_result <= res_fit;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/int32_divide_remainder_unit_top.sv =====
// Top level of the 32-bit divide/remainder unit: front end, queue and
// pipelined restoring divider. Depends on divu_pkg, divu_front, divu_queue
// and divu_back.
//
// Usage:
//   s_axis carries one operation per transaction: op selects unsigned
//   quotient, unsigned remainder, signed quotient or signed remainder.
//   m_axis returns one 32-bit result per operation, in order.
//   A zero divisor gives result 0 for every op; signed results wrap, so the
//   most negative value divided by -1 returns the most negative value.
// Throughput: one transaction per cycle while m_axis_tready stays high,
//   set by the divider pipeline, one quotient bit per stage over DATA_WIDTH stages.
// Path: the accepting edge loads the front register, then the item moves through
//   the queue, pipeline entry register, DATA_WIDTH steps and output register to
//   m_axis_tvalid in that order; a stall can hold it at any point.
// Reset: rst clears every valid bit and the queue; in-flight operations are
//   dropped and s_axis_tready is already high while rst is held.
// Stall: while a result waits and m_axis_tready is low, the output register holds
//   and the whole divider pipeline halts; the queue and front end keep taking
//   transactions until they fill, then s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module int32_divide_remainder_unit_top
  import divu_pkg::*;
#(
  parameter int DATA_WIDTH = DIVU_DATA_WIDTH
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire  [IN_TDATA_W-1:0]  s_axis_tdata,   // op[1:0], dividend[33:2], divisor[65:34]
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // result[31:0]
);

  localparam int Q_WIDTH = CTL_W + 2 * DATA_WIDTH;

  // Unpack the input transaction
  logic [OP_W-1:0]    in_op;
  logic [FIELD_W-1:0] in_dividend;
  logic [FIELD_W-1:0] in_divisor;

  assign in_op       = s_axis_tdata[OP_W-1:0];
  assign in_dividend = s_axis_tdata[OP_W+FIELD_W-1:OP_W];
  assign in_divisor  = s_axis_tdata[OP_W+2*FIELD_W-1:OP_W+FIELD_W];

  // Front end to queue
  logic                  fr_valid;
  logic                  fr_ready;
  divu_ctl_t             fr_ctl;
  logic [DATA_WIDTH-1:0] fr_num;
  logic [DATA_WIDTH-1:0] fr_den;

  // Queue to back end
  logic                  q_valid;
  logic                  q_ready;
  logic [Q_WIDTH-1:0]    q_data;

  logic [RESULT_W-1:0]   result;

  divu_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_op       (in_op),
    .in_dividend (in_dividend),
    .in_divisor  (in_divisor),
    .out_valid   (fr_valid),
    .out_ready   (fr_ready),
    .out_ctl     (fr_ctl),
    .out_num     (fr_num),
    .out_den     (fr_den)
  );

  divu_queue #(
    .WIDTH (Q_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   ({fr_ctl, fr_num, fr_den}),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  divu_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_ctl     (divu_ctl_t'(q_data[Q_WIDTH-1:2*DATA_WIDTH])),
    .in_num     (q_data[2*DATA_WIDTH-1:DATA_WIDTH]),
    .in_den     (q_data[DATA_WIDTH-1:0]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (result)
  );

  // Pad the result to whole bytes
  generate
    if (OUT_TDATA_W == RESULT_W) begin : g_out_eq
      assign m_axis_tdata = result;
    end else begin : g_out_pad
      assign m_axis_tdata = {{(OUT_TDATA_W - RESULT_W){1'b0}}, result};
    end
  endgenerate

`ifndef ASSERT_OFF
  // A front-end item blocked by a full queue must still be there next cycle
  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    (fr_valid && !fr_ready) |=> fr_valid)
    else $error("front end dropped an item while the queue was full");

  // Input backpressure only while the front register is occupied
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> fr_valid)
    else $error("s_axis_tready low with an empty front register");

  // Divider halts only when a result is waiting on a stalled receiver
  a_back_stall: assert property (@(posedge clk) disable iff (rst)
    !q_ready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("divider pipeline stalled without output backpressure");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_int32_divide_remainder_unit_top.sv =====
// Self-checking bench for int32_divide_remainder_unit_top: the four divide ops
// are run through directed corners and random streams and checked in order.
// Depends on divu_pkg and the int32_divide_remainder_unit_top RTL.
`timescale 1ns / 1ps

module tb_int32_divide_remainder_unit_top;
  import divu_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_OPS   = 1700;
  localparam int DRAIN_CYCLES = DIVU_DATA_WIDTH + 32;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;

  // One divide request, and the same request with the result it must produce
  typedef struct {
    divu_op_t    op;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct {
    div_req_t    req;
    logic [31:0] result;
  } div_outcome_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // op[1:0], dividend[33:2], divisor[65:34]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // result[31:0]

  div_req_t     reqs_to_send[$];
  div_outcome_t results_due[$];
  div_req_t     req_on_bus;
  int           reqs_total  = 0;
  int           reqs_taken  = 0;
  int           bad_results = 0;
  int           cycle_count = 0;
  bit           offer_taken = 1'b0;
  int           send_gap    = 0;
  int           stall_left  = 0;
  int           hold_left   = 0;
  int           holds_done  = 0;

  // Every fourth stretch of 150 transactions skips the random idling on both sides
  wire steady_run = ((reqs_taken / 150) % 4) == 2;

  int32_divide_remainder_unit_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Truncating divide by restoring division on the operand magnitudes.
  // A zero divisor gives zero for every op.
  function automatic logic [31:0] div_result(divu_op_t op, logic [31:0] dividend,
                                             logic [31:0] divisor);
    logic [31:0] num;
    logic [31:0] den;
    logic [31:0] quo;
    logic [31:0] rem;
    logic        neg_num;
    logic        neg_den;
    logic        carry;
    num = dividend;
    den = divisor;
    quo = '0;
    rem = '0;
    neg_num = 1'b0;
    neg_den = 1'b0;
    if (divisor == '0) return '0;
    if (op == OP_SQUO || op == OP_SREM) begin
      neg_num = dividend[31];
      neg_den = divisor[31];
      if (neg_num) num = -dividend;
      if (neg_den) den = -divisor;
    end
    // Shift in one dividend bit per step; the bit shifted out of the partial
    // remainder stands for 2^32, so a set carry always allows the subtract.
    for (int i = 31; i >= 0; i--) begin
      carry = rem[31];
      rem = {rem[30:0], num[i]};
      if (carry || rem >= den) begin
        rem = rem - den;
        quo[i] = 1'b1;
      end
    end
    case (op)
      OP_UQUO: return quo;
      OP_UREM: return rem;
      OP_SQUO: return (neg_num != neg_den) ? -quo : quo;
      default: return neg_num ? -rem : rem;
    endcase
  endfunction

  // Mostly back-to-back, sometimes a short pause, rarely a long one
  function automatic int idle_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Build the request stream, then wait for every result and the drain time
  initial begin
    logic [31:0] corner_num[6];
    logic [31:0] corner_den[6];
    logic [31:0] num;
    logic [31:0] den;
    logic [31:0] picks[4];
    div_req_t    req;
    int          kind;

    // Most negative by -1, divide by zero, all-ones by one, zero by -1,
    // and both truncation directions with mixed signs
    corner_num = '{32'h8000_0000, 32'h1234_5678, 32'hFFFF_FFFF,
                   32'h0000_0000, 32'hFFFF_FFF9, 32'h0000_0007};
    corner_den = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
                   32'hFFFF_FFFF, 32'h0000_0002, 32'hFFFF_FFFE};
    for (int c = 0; c < 6; c++) begin
      for (int o = 0; o < 4; o++) begin
        req.op       = divu_op_t'(o);
        req.dividend = corner_num[c];
        req.divisor  = corner_den[c];
        reqs_to_send.push_back(req);
      end
    end

    for (int n = 0; n < RANDOM_OPS; n++) begin
      kind = $urandom_range(0, 9);
      num  = $urandom();
      den  = $urandom();
      case (kind)
        4: den = $urandom_range(0, 1) ? $urandom_range(1, 255) : -$urandom_range(1, 255);
        5: den = '0;
        6: begin
          picks = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
          num = picks[$urandom_range(0, 3)];
          den = $urandom_range(0, 1) ? $urandom_range(1, 1000) : -$urandom_range(1, 1000);
        end
        7: num = $urandom_range(0, 1000);
        8: begin
          // Exact multiples exercise a zero remainder
          den = $urandom_range(1, 65535);
          num = den * $urandom_range(0, 65535);
          if ($urandom_range(0, 1)) num = -num;
        end
        9: begin
          picks = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
          den = picks[$urandom_range(0, 3)];
        end
        default: begin
        end
      endcase
      req.op       = divu_op_t'($urandom_range(0, 3));
      req.dividend = num;
      req.divisor  = den;
      reqs_to_send.push_back(req);
    end
    reqs_total = reqs_to_send.size();

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    while (reqs_taken < reqs_total || results_due.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (bad_results == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Sender: hold the request until a transaction takes it, then advance
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !offer_taken) begin
      // hold the current request
    end else begin
      offer_taken = 1'b0;
      if (send_gap > 0 && !steady_run) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (reqs_to_send.size() > 0) begin
        req_on_bus = reqs_to_send.pop_front();
        s_axis_tdata <= {{(IN_TDATA_W - IN_PACKED_W){1'b0}},
                         req_on_bus.divisor, req_on_bus.dividend, req_on_bus.op};
        s_axis_tvalid <= 1'b1;
        send_gap = idle_cycles();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Record each accepted request with the result it must produce
  always @(posedge clk) begin
    div_outcome_t due;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      due.req    = req_on_bus;
      due.result = div_result(req_on_bus.op, req_on_bus.dividend, req_on_bus.divisor);
      results_due.push_back(due);
      reqs_taken++;
      offer_taken = 1'b1;
    end
  end

  // Receiver: random stalls, plus two long hold-offs that fill the pipeline
  // and queue so the input side has to back-pressure the sender
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (holds_done < 2 && reqs_taken >= (holds_done == 0 ? 400 : 1200)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0 && !steady_run) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = idle_cycles();
      end
    end
  end

  // Compare each result transaction with the oldest outstanding request
  always @(posedge clk) begin
    div_outcome_t due;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result %h with no request outstanding",
                 $realtime, m_axis_tdata[RESULT_W-1:0]);
        bad_results++;
      end else begin
        due = results_due.pop_front();
        if (m_axis_tdata[RESULT_W-1:0] !== due.result) begin
          $display("%0t: %s %h / %h: expected result %h, actual %h", $realtime,
                   due.req.op.name(), due.req.dividend, due.req.divisor,
                   due.result, m_axis_tdata[RESULT_W-1:0]);
          bad_results++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d requests taken, %0d results outstanding",
               $realtime, reqs_taken, results_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
